>>> hw/rtl/dblcd_pkg.sv
// shared types, register map and command codes for the dual-bank lcd refresh engine
`default_nettype none

package dblcd_pkg;

    // framebuffer item as taken on the input channel
    typedef struct packed {
        logic       operation;
        logic       bank;
        logic [1:0] page;
        logic [5:0] column;
        logic [7:0] pixel_byte;
    } item_t;

    // one bus write on the output channel
    typedef struct packed {
        logic       chip_select;
        logic       is_data;
        logic [7:0] bus_value;
        logic       last;
    } bus_write_t;

    typedef struct packed {
        logic [6:0] bank0_column_offset;
        logic [6:0] bank1_column_offset;
        logic       bank0_reverse_scan;
        logic       bank1_reverse_scan;
        logic [4:0] start_line;
    } cfg_t;

    // classified work handed from the front part to the back part
    typedef struct packed {
        logic       init;
        logic       bank;
        logic       page_emit;
        logic [1:0] page;
        logic       write_emit;
        logic [6:0] col_addr;
        logic [7:0] pixel;
    } job_t;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_BANK0_OFFSET = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BANK1_OFFSET = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BANK0_SCAN   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BANK1_SCAN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_START_LINE   = 3'd4;

    localparam logic [6:0] BANK0_OFFSET_RESET = 7'd19;
    localparam logic [6:0] BANK1_OFFSET_RESET = 7'd0;
    localparam logic       BANK0_SCAN_RESET   = 1'b1;
    localparam logic       BANK1_SCAN_RESET   = 1'b0;
    localparam logic [4:0] START_LINE_RESET   = 5'd0;

    localparam logic [7:0] SHADOW_RESET = 8'hFF;

    localparam logic [7:0] CMD_END_RMW      = 8'hEE;
    localparam logic [7:0] CMD_STATIC_OFF   = 8'hA4;
    localparam logic [7:0] CMD_DUTY_32      = 8'hA9;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'hAF;
    localparam logic [7:0] CMD_ADC_REVERSE  = 8'hA1;
    localparam logic [7:0] CMD_ADC_FORWARD  = 8'hA0;
    localparam logic [7:0] CMD_SOFT_RESET   = 8'hE2;
    localparam logic [7:0] CMD_START_LINE   = 8'hC0;
    localparam logic [7:0] CMD_SET_PAGE     = 8'hB8;

    localparam logic [2:0] INIT_LEN = 3'd7;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    function automatic logic [7:0] init_cmd(
        input logic [2:0] step,
        input logic       reverse,
        input logic [4:0] line
    );
        logic [7:0] cmd;
        unique case (step)
            3'd0:    cmd = CMD_END_RMW;
            3'd1:    cmd = CMD_STATIC_OFF;
            3'd2:    cmd = CMD_DUTY_32;
            3'd3:    cmd = CMD_DISPLAY_ON;
            3'd4:    cmd = reverse ? CMD_ADC_REVERSE : CMD_ADC_FORWARD;
            3'd5:    cmd = CMD_SOFT_RESET;
            default: cmd = CMD_START_LINE | {3'd0, line};
        endcase
        return cmd;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dblcd_cfg_regs.sv
// apb configuration registers of the lcd refresh engine
`default_nettype none

module dblcd_cfg_regs
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dblcd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [dblcd_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [dblcd_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready,
    output dblcd_pkg::cfg_t                           cfg
);

    dblcd_pkg::cfg_t                     cfg_reg;
    dblcd_pkg::cfg_t                     cfg_next;
    logic [dblcd_pkg::REG_IDX_W-1:0]     reg_idx;
    logic                                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[dblcd_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                dblcd_pkg::REG_BANK0_OFFSET: cfg_next.bank0_column_offset = pwdata[6:0];
                dblcd_pkg::REG_BANK1_OFFSET: cfg_next.bank1_column_offset = pwdata[6:0];
                dblcd_pkg::REG_BANK0_SCAN:   cfg_next.bank0_reverse_scan  = pwdata[0];
                dblcd_pkg::REG_BANK1_SCAN:   cfg_next.bank1_reverse_scan  = pwdata[0];
                dblcd_pkg::REG_START_LINE:   cfg_next.start_line          = pwdata[4:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dblcd_pkg::REG_BANK0_OFFSET: prdata = {25'd0, cfg_reg.bank0_column_offset};
            dblcd_pkg::REG_BANK1_OFFSET: prdata = {25'd0, cfg_reg.bank1_column_offset};
            dblcd_pkg::REG_BANK0_SCAN:   prdata = {31'd0, cfg_reg.bank0_reverse_scan};
            dblcd_pkg::REG_BANK1_SCAN:   prdata = {31'd0, cfg_reg.bank1_reverse_scan};
            dblcd_pkg::REG_START_LINE:   prdata = {27'd0, cfg_reg.start_line};
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bank0_column_offset <= dblcd_pkg::BANK0_OFFSET_RESET;
            cfg_reg.bank1_column_offset <= dblcd_pkg::BANK1_OFFSET_RESET;
            cfg_reg.bank0_reverse_scan  <= dblcd_pkg::BANK0_SCAN_RESET;
            cfg_reg.bank1_reverse_scan  <= dblcd_pkg::BANK1_SCAN_RESET;
            cfg_reg.start_line          <= dblcd_pkg::START_LINE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dblcd_front.sv
// front part: takes items, checks them against the shadow memory, queues work
`default_nettype none

module dblcd_front #(
    parameter int BANK_COUNT   = 2,
    parameter int BANK_COLUMNS = 61,
    parameter int PAGE_COUNT   = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire dblcd_pkg::item_t   item,
    input  wire dblcd_pkg::cfg_t    cfg,
    output logic                    job_push,
    output dblcd_pkg::job_t         job,
    input  wire logic               queue_full
);

    localparam int PAGE_STRIDE = BANK_COUNT * BANK_COLUMNS;
    localparam int DEPTH       = PAGE_STRIDE * PAGE_COUNT;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [7:0]        shadow_mem [DEPTH];
    logic [7:0]        rd_data_reg;

    logic              clr_active_reg, clr_active_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_init_reg;
    logic              s1_byte_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    dblcd_pkg::item_t  s1_item_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;

    logic              accept;
    logic              bank_ok, page_ok, col_ok;
    logic              is_init, is_byte;
    logic [31:0]       idx_calc;
    logic [IDX_W-1:0]  idx;

    logic              s1_fire;
    logic [7:0]        old_byte;
    logic              changed;
    logic              s1_wr;
    logic [6:0]        offset;
    logic [7:0]        col_sum;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [7:0]        mem_wdata;

    // classification of the incoming item
    assign bank_ok  = {31'd0, item.bank} < 32'(BANK_COUNT);
    assign page_ok  = {30'd0, item.page} < 32'(PAGE_COUNT);
    assign col_ok   = {26'd0, item.column} < 32'(BANK_COLUMNS);
    assign is_init  = item.operation && bank_ok;
    assign is_byte  = !item.operation && bank_ok && page_ok && col_ok;
    assign idx_calc = {30'd0, item.page} * 32'(PAGE_STRIDE)
                    + {31'd0, item.bank} * 32'(BANK_COLUMNS)
                    + {26'd0, item.column};
    assign idx      = idx_calc[IDX_W-1:0];

    assign s1_fire    = s1_valid_reg && !queue_full;
    assign item_ready = !clr_active_reg && (!s1_valid_reg || !queue_full);
    assign accept     = item_valid && item_ready;

    // compare against the shadow, with the write of the previous item forwarded
    assign old_byte = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign changed  = old_byte != s1_item_reg.pixel_byte;
    assign s1_wr    = s1_fire && s1_byte_reg && changed;
    assign offset   = s1_item_reg.bank ? cfg.bank1_column_offset : cfg.bank0_column_offset;
    assign col_sum  = {1'b0, offset} + {2'd0, s1_item_reg.column};

    always_comb
    begin
        job.init       = s1_init_reg;
        job.bank       = s1_item_reg.bank;
        job.page_emit  = s1_byte_reg && (s1_item_reg.column == 6'd0);
        job.page       = s1_item_reg.page;
        job.write_emit = s1_byte_reg && changed;
        job.col_addr   = col_sum[6:0];
        job.pixel      = s1_item_reg.pixel_byte;
    end

    assign job_push = s1_fire && (job.init || job.page_emit || job.write_emit);

    // shadow write port, shared with the clearing pass after reset
    assign mem_we    = clr_active_reg || s1_wr;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : s1_idx_reg;
    assign mem_wdata = clr_active_reg ? dblcd_pkg::SHADOW_RESET : s1_item_reg.pixel_byte;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            shadow_mem[mem_waddr] <= mem_wdata;
        end
        if (accept && is_byte)
        begin
            rd_data_reg <= shadow_mem[idx];
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_IDX)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        priority if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item;
            s1_init_reg  <= is_init;
            s1_byte_reg  <= is_byte;
            s1_idx_reg   <= idx;
            fwd_hit_reg  <= s1_wr && (s1_idx_reg == idx);
            fwd_data_reg <= s1_item_reg.pixel_byte;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dblcd_queue.sv
// short job queue between the front and back parts
`default_nettype none

module dblcd_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire dblcd_pkg::job_t   push_job,
    output logic                   full,
    output logic                   empty,
    output dblcd_pkg::job_t        head,
    input  wire logic              pop
);

    localparam int CNT_W = dblcd_pkg::QUEUE_PTR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(dblcd_pkg::QUEUE_DEPTH);

    dblcd_pkg::job_t                      entry_reg [dblcd_pkg::QUEUE_DEPTH];
    logic [dblcd_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dblcd_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic                                 do_push, do_pop;

    assign full    = count_reg == DEPTH_CNT;
    assign empty   = count_reg == '0;
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/dblcd_back.sv
// back part: expands queued jobs into bus writes through an output register
`default_nettype none

module dblcd_back
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  queue_empty,
    input  wire dblcd_pkg::job_t       head,
    output logic                       pop,
    input  wire dblcd_pkg::cfg_t       cfg,
    output logic                       wr_valid,
    input  wire logic                  wr_ready,
    output dblcd_pkg::bus_write_t      wr
);

    logic                    out_valid_reg, out_valid_next;
    dblcd_pkg::bus_write_t   out_reg;
    logic [2:0]              step_reg, step_next;

    logic                    load;
    logic                    emit;
    logic [2:0]              count;
    logic [2:0]              byte_step;
    logic                    reverse;
    logic [7:0]              value;
    logic                    is_data;
    logic                    last;

    assign load    = !out_valid_reg || wr_ready;
    assign emit    = load && !queue_empty;
    assign reverse = head.bank ? cfg.bank1_reverse_scan : cfg.bank0_reverse_scan;

    always_comb
    begin
        if (head.init)
            count = dblcd_pkg::INIT_LEN;
        else
            count = {2'd0, head.page_emit} + (head.write_emit ? 3'd2 : 3'd0);
    end

    // byte jobs: optional page command, then optional column command and data
    assign byte_step = step_reg - {2'd0, head.page_emit};

    always_comb
    begin
        is_data = 1'b0;
        priority if (head.init)
            value = dblcd_pkg::init_cmd(step_reg, reverse, cfg.start_line);
        else if (head.page_emit && step_reg == 3'd0)
            value = dblcd_pkg::CMD_SET_PAGE | {6'd0, head.page};
        else if (byte_step == 3'd0)
            value = {1'b0, head.col_addr};
        else
        begin
            value   = head.pixel;
            is_data = 1'b1;
        end
    end

    assign last = step_reg == (count - 3'd1);
    assign pop  = emit && last;

    always_comb
    begin
        step_next = step_reg;
        if (emit)
            step_next = last ? 3'd0 : step_reg + 3'd1;
        priority if (emit)
            out_valid_next = 1'b1;
        else if (wr_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg.chip_select <= head.bank;
            out_reg.is_data     <= is_data;
            out_reg.bus_value   <= value;
            out_reg.last        <= last;
        end
    end

    assign wr_valid = out_valid_reg;
    assign wr       = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/dual_bank_lcd_dirty_refresh.sv
// top level of the dual-bank lcd refresh engine with shadow framebuffer
//
// item_valid/item_ready/item take framebuffer bytes in refresh order, or an init request
// for one bank. wr_valid/wr_ready/wr give the bus writes (chip select, a0, byte, last).
// configuration registers sit on the apb port at byte addresses 0, 4, 8, 12 and 16.
// a byte at column 0 gives a set-page command; a byte that differs from the shadow
// copy gives a set-column command and a data write; an init request gives seven
// commands. unchanged bytes off column 0 and out-of-range items give nothing.
// throughput: one bus write per cycle while wr_ready is high; a request makes
// 0 to 7 writes; the front takes one request per cycle while the
// four-entry job queue has room.
// reset: the shadow memory is filled with ones by a clearing pass over all
// BANK_COUNT*BANK_COLUMNS*PAGE_COUNT entries (488 by default) during which
// item_ready stays low; registers may be written meanwhile.
// when the receiver stalls the output register holds, the queue fills and then
// item_ready drops.
`default_nettype none

module dual_bank_lcd_dirty_refresh #(
    parameter int BANK_COUNT   = 2,
    parameter int BANK_COLUMNS = 61,
    parameter int PAGE_COUNT   = 4
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire dblcd_pkg::item_t                  item,
    output logic                                   wr_valid,
    input  wire logic                              wr_ready,
    output dblcd_pkg::bus_write_t                  wr,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dblcd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [dblcd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [dblcd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                   pready
);

    dblcd_pkg::cfg_t   cfg;
    dblcd_pkg::job_t   push_job;
    dblcd_pkg::job_t   head_job;
    logic              job_push;
    logic              queue_full;
    logic              queue_empty;
    logic              job_pop;

    dblcd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dblcd_front #(
        .BANK_COUNT   (BANK_COUNT),
        .BANK_COLUMNS (BANK_COLUMNS),
        .PAGE_COUNT   (PAGE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg),
        .job_push   (job_push),
        .job        (push_job),
        .queue_full (queue_full)
    );

    dblcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (head_job),
        .pop      (job_pop)
    );

    dblcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .head        (head_job),
        .pop         (job_pop),
        .cfg         (cfg),
        .wr_valid    (wr_valid),
        .wr_ready    (wr_ready),
        .wr          (wr)
    );

endmodule

`default_nettype wire

>>> test/tb_dual_bank_lcd_dirty_refresh.sv
// self-checking testbench for the dual-bank lcd refresh engine with shadow framebuffer
module tb_dual_bank_lcd_dirty_refresh;
    timeunit 1ns;
    timeprecision 1ps;

    import dblcd_pkg::*;

    localparam int BANKS     = 2;
    localparam int COLUMNS   = 61;
    localparam int PAGES     = 4;
    localparam int REG_SPARE = 5;    // address that decodes to no register
    localparam int SETTLE    = 10;   // cycles for the pipeline to drain silent jobs

    class lcd_bus_scoreboard;
        logic [7:0] shadow_bytes [BANKS*COLUMNS*PAGES];
        cfg_t       settings;
        bus_write_t expected_bus_writes [$];
        int         mismatches;
        int         writes_checked;

        function new();
            foreach (shadow_bytes[i])
                shadow_bytes[i] = SHADOW_RESET;
            settings.bank0_column_offset = BANK0_OFFSET_RESET;
            settings.bank1_column_offset = BANK1_OFFSET_RESET;
            settings.bank0_reverse_scan  = BANK0_SCAN_RESET;
            settings.bank1_reverse_scan  = BANK1_SCAN_RESET;
            settings.start_line          = START_LINE_RESET;
            mismatches     = 0;
            writes_checked = 0;
        endfunction

        function int shadow_index(logic [1:0] page, logic bank, logic [5:0] column);
            return int'(page) * BANKS * COLUMNS + int'(bank) * COLUMNS + int'(column);
        endfunction

        function void set_register(int idx, logic [31:0] value);
            case (idx)
                REG_BANK0_OFFSET: settings.bank0_column_offset = value[6:0];
                REG_BANK1_OFFSET: settings.bank1_column_offset = value[6:0];
                REG_BANK0_SCAN:   settings.bank0_reverse_scan  = value[0];
                REG_BANK1_SCAN:   settings.bank1_reverse_scan  = value[0];
                REG_START_LINE:   settings.start_line          = value[4:0];
                default: ;
            endcase
        endfunction

        function void add_write(logic bank, logic data, logic [7:0] value);
            bus_write_t w;
            w.chip_select = bank;
            w.is_data     = data;
            w.bus_value   = value;
            w.last        = 1'b0;
            expected_bus_writes.push_back(w);
        endfunction

        function void predict_bus_writes(item_t req);
            bus_write_t w;
            int         n;
            int         idx;
            logic [6:0] offset;
            logic [7:0] col_sum;
            logic       reverse;
            n = expected_bus_writes.size();
            if (req.operation)
            begin
                reverse = req.bank ? settings.bank1_reverse_scan : settings.bank0_reverse_scan;
                add_write(req.bank, 1'b0, CMD_END_RMW);
                add_write(req.bank, 1'b0, CMD_STATIC_OFF);
                add_write(req.bank, 1'b0, CMD_DUTY_32);
                add_write(req.bank, 1'b0, CMD_DISPLAY_ON);
                add_write(req.bank, 1'b0, reverse ? CMD_ADC_REVERSE : CMD_ADC_FORWARD);
                add_write(req.bank, 1'b0, CMD_SOFT_RESET);
                add_write(req.bank, 1'b0, CMD_START_LINE | {3'd0, settings.start_line});
            end
            else if (int'(req.column) < COLUMNS)
            begin
                idx = shadow_index(req.page, req.bank, req.column);
                if (req.column == 6'd0)
                    add_write(req.bank, 1'b0, CMD_SET_PAGE | {6'd0, req.page});
                if (shadow_bytes[idx] != req.pixel_byte)
                begin
                    shadow_bytes[idx] = req.pixel_byte;
                    offset = req.bank ? settings.bank1_column_offset
                                      : settings.bank0_column_offset;
                    // column address wraps to 7 bits
                    col_sum = {1'b0, offset} + {2'b00, req.column};
                    add_write(req.bank, 1'b0, {1'b0, col_sum[6:0]});
                    add_write(req.bank, 1'b1, req.pixel_byte);
                end
            end
            if (expected_bus_writes.size() > n)
            begin
                w = expected_bus_writes.pop_back();
                w.last = 1'b1;
                expected_bus_writes.push_back(w);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
            if (got_v !== want_v)
            begin
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $time, name, want_v, got_v);
                mismatches++;
            end
        endfunction

        function void check_write(bus_write_t got);
            bus_write_t want;
            writes_checked++;
            if (expected_bus_writes.size() == 0)
            begin
                $display("%0t ns: unexpected bus write, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = expected_bus_writes.pop_front();
            compare_field("chip_select", 8'(want.chip_select), 8'(got.chip_select));
            compare_field("is_data", 8'(want.is_data), 8'(got.is_data));
            compare_field("bus_value", want.bus_value, got.bus_value);
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_ready;
    item_t                 item;
    logic                  wr_valid;
    logic                  wr_ready;
    bus_write_t            wr;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  steady_flow;
    int                    requests_sent;
    int                    settings_used;
    lcd_bus_scoreboard     sb;

    dual_bank_lcd_dirty_refresh DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            sb.check_write(wr);
        wr_ready <= rst_n && (steady_flow || ($urandom_range(99) >= 19));
    end

    function automatic item_t make_request(logic op, logic bank, logic [1:0] page,
                                           logic [5:0] column, logic [7:0] pixel);
        item_t req;
        req.operation  = op;
        req.bank       = bank;
        req.page       = page;
        req.column     = column;
        req.pixel_byte = pixel;
        return req;
    endfunction

    task automatic send_request(input item_t req);
        if (!steady_flow && $urandom_range(99) < 19)
        begin
            item_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 40);
        end
        item_valid <= 1'b1;
        item       <= req;
        do @(posedge clk); while (!item_ready);
        sb.predict_bus_writes(req);
        requests_sent++;
    endtask

    task automatic write_register(input int idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_register(idx, value);
    endtask

    // upper bits of each write are random and must be ignored
    task automatic apply_setting(input logic [6:0] off0, input logic [6:0] off1,
                                 input logic scan0, input logic scan1, input logic [4:0] line);
        write_register(REG_SPARE, $urandom);
        write_register(REG_BANK0_OFFSET, (32'($urandom) << 7) | 32'(off0));
        write_register(REG_BANK1_OFFSET, (32'($urandom) << 7) | 32'(off1));
        write_register(REG_BANK0_SCAN, (32'($urandom) << 1) | 32'(scan0));
        write_register(REG_BANK1_SCAN, (32'($urandom) << 1) | 32'(scan1));
        write_register(REG_START_LINE, (32'($urandom) << 5) | 32'(line));
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_for_idle();
        item_valid <= 1'b0;
        while (sb.expected_bus_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // a stretch of one page row in refresh order, some bytes left as they are
    task automatic refresh_run(inout int counted);
        logic       bank;
        logic [1:0] page;
        logic [5:0] column;
        logic [7:0] pixel;
        int         len;
        bank   = 1'($urandom_range(1));
        page   = 2'($urandom_range(3));
        column = ($urandom_range(99) < 40) ? 6'd0 : 6'($urandom_range(COLUMNS - 1));
        len    = $urandom_range(12, 3);
        for (int k = 0; k < len && int'(column) < COLUMNS; k++)
        begin
            if ($urandom_range(99) < 30)
                pixel = sb.shadow_bytes[sb.shadow_index(page, bank, column)];
            else
                pixel = 8'($urandom);
            send_request(make_request(1'b0, bank, page, column, pixel));
            counted++;
            column++;
        end
    endtask

    task automatic noise_request(inout int counted);
        item_t req;
        req = item_t'($urandom);
        req.operation = ($urandom_range(99) < 25);
        send_request(req);
        if (req.operation || int'(req.column) < COLUMNS)
            counted++;
    endtask

    initial
    begin
        int counted;
        sb            = new();
        requests_sent = 0;
        settings_used = 0;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        wr_ready    <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        steady_flow <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // register values as after reset
        send_request(make_request(1'b1, 1'b0, 2'd3, 6'd63, 8'hFF));
        send_request(make_request(1'b1, 1'b1, 2'd0, 6'd0, 8'h00));
        send_request(make_request(1'b0, 1'b0, 2'd0, 6'd0, 8'hFF));
        send_request(make_request(1'b0, 1'b0, 2'd0, 6'd0, 8'h00));
        send_request(make_request(1'b0, 1'b0, 2'd0, 6'd1, 8'h00));
        send_request(make_request(1'b0, 1'b0, 2'd0, 6'd1, 8'h00));
        send_request(make_request(1'b0, 1'b1, 2'd3, 6'd60, 8'hA5));
        send_request(make_request(1'b0, 1'b1, 2'd3, 6'd61, 8'h12));
        send_request(make_request(1'b0, 1'b0, 2'd2, 6'd63, 8'hFF));
        send_request(make_request(1'b0, 1'b1, 2'd1, 6'd0, 8'h5A));
        wait_for_idle();

        // largest offsets so the column address wraps
        apply_setting(7'd127, 7'd127, 1'b0, 1'b1, 5'd31);
        send_request(make_request(1'b1, 1'b0, 2'd1, 6'd42, 8'hC3));
        send_request(make_request(1'b1, 1'b1, 2'd2, 6'd21, 8'h3C));
        send_request(make_request(1'b0, 1'b0, 2'd1, 6'd60, 8'h01));
        send_request(make_request(1'b0, 1'b1, 2'd1, 6'd0, 8'h7E));
        send_request(make_request(1'b0, 1'b1, 2'd2, 6'd5, 8'hFF));
        send_request(make_request(1'b0, 1'b0, 2'd3, 6'd0, 8'hFF));
        send_request(make_request(1'b0, 1'b0, 2'd3, 6'd33, 8'h80));

        for (int p = 0; p < 5; p++)
        begin
            wait_for_idle();
            steady_flow <= (p == 2);
            case (p)
                0: apply_setting(7'd0, 7'd0, 1'b0, 1'b0, 5'd0);
                2: apply_setting(7'd127, 7'd127, 1'b1, 1'b1, 5'd31);
                4: apply_setting(BANK0_OFFSET_RESET, BANK1_OFFSET_RESET,
                                 BANK0_SCAN_RESET, BANK1_SCAN_RESET, START_LINE_RESET);
                default: apply_setting(7'($urandom), 7'($urandom), 1'($urandom),
                                       1'($urandom), 5'($urandom));
            endcase
            counted = 0;
            while (counted < 40)
            begin
                if ($urandom_range(99) < 80)
                    refresh_run(counted);
                else
                    noise_request(counted);
            end
        end

        wait_for_idle();
        $display("covered %0d requests and %0d bus writes under %0d register settings",
                 requests_sent, sb.writes_checked, settings_used + 1);
        $display("requests included init sequences, page starts, unchanged and out-of-range bytes");
        if (sb.mismatches == 0 && sb.expected_bus_writes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
